/* rtl/core/lrpf_pkg.sv */
`timescale 1ns / 1ps

package lrpf_pkg;

   // frame geometry
   localparam int COLUMNS     = 128;
   localparam int PAGES       = 8;
   localparam int ROWS        = PAGES * 8;
   localparam int STORE_DEPTH = PAGES * COLUMNS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // pixel bit inside a page byte
   localparam logic [7:0] PIXEL_BIT = 8'h01;

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      KIND_DRAW  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // packed request payload, highest field first
   typedef struct packed {
      logic [4:0] pad;
      logic [6:0] read_column;
      logic [2:0] read_page;
      logic       erase;
      logic [7:0] y_end;
      logic [7:0] x_end;
      logic [7:0] y_start;
      logic [7:0] x_start;
   } req_data_type;

endpackage

/* rtl/core/line_raster_to_page_framebuffer_core.sv */
`timescale 1ns / 1ps

// channel   ports                  width  contents
// request   req_tvalid/tready      48+2   tdata: x_start, y_start, x_end, y_end, erase,
//                                         read_page, read_column; tuser: kind
// response  rsp_tvalid/tready      8      tdata: read_data
//
// a draw reads and then rewrites one frame byte per plotted pixel (read-modify-write
// through the single store port); a clear writes one store byte per cycle.
// after reset a clearing pass zeroes the store; req_tready stays low during it.
// req_tready is high only while idle; a finished result waits in the output register
// and the next item is accepted while it waits.

module line_raster_to_page_framebuffer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_start, y_start, x_end, y_end, erase, read_page,
                                    // read_column, zero fill
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // read_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_READ_DATA,
      ST_RESP
   } state_type;

   localparam int AW = lrpf_pkg::ADDR_W;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             clr_cnt_ff, clr_cnt_in;
   logic                      clr_cmd_ff, clr_cmd_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]                rsp_tdata_ff, rsp_tdata_in;
   logic [7:0]                result_ff, result_in;
   lrpf_pkg::req_data_type    cmd_ff, cmd_in;
   lrpf_pkg::kind_type        kind_ff, kind_in;

   // line walker
   logic [7:0]                x_ff, x_in;
   logic [7:0]                y_ff, y_in;
   logic [7:0]                end_ff, end_in;
   logic [7:0]                dmaj_ff, dmaj_in;
   logic [7:0]                dmin_ff, dmin_in;
   logic                      maj_neg_ff, maj_neg_in;
   logic                      min_neg_ff, min_neg_in;
   logic                      x_major_ff, x_major_in;
   logic                      incl_ff, incl_in;
   logic signed [10:0]        err_ff, err_in;

   // frame store
   logic [7:0]                mem [lrpf_pkg::STORE_DEPTH];
   logic [7:0]                rd_data_ff;
   logic [AW-1:0]             mem_addr;
   logic                      mem_we;
   logic [7:0]                mem_wdata;

   logic [AW-1:0]             pix_addr;
   logic                      pix_on;
   logic [7:0]                pix_mask;
   logic [AW-1:0]             rd_addr;
   logic                      rd_on;
   logic [7:0]                dx_abs, dy_abs;
   logic [7:0]                maj, mnr, maj_next, mnr_next;
   logic signed [10:0]        err_add;
   logic                      min_step;
   logic                      line_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      pix_addr = AW'(32'(y_ff[7:3]) * lrpf_pkg::COLUMNS + 32'(x_ff));
      pix_on   = (32'(x_ff) < lrpf_pkg::COLUMNS) && (32'(y_ff) < lrpf_pkg::ROWS);
      pix_mask = lrpf_pkg::PIXEL_BIT << y_ff[2:0];
      rd_addr  = AW'(32'(cmd_ff.read_page) * lrpf_pkg::COLUMNS + 32'(cmd_ff.read_column));
      rd_on    = (32'(cmd_ff.read_page) < lrpf_pkg::PAGES)
              && (32'(cmd_ff.read_column) < lrpf_pkg::COLUMNS);
      dx_abs   = (cmd_ff.x_end >= cmd_ff.x_start) ? cmd_ff.x_end - cmd_ff.x_start
                                                  : cmd_ff.x_start - cmd_ff.x_end;
      dy_abs   = (cmd_ff.y_end >= cmd_ff.y_start) ? cmd_ff.y_end - cmd_ff.y_start
                                                  : cmd_ff.y_start - cmd_ff.y_end;

      // shared stepping unit: one error add and compare per pixel
      maj      = x_major_ff ? x_ff : y_ff;
      mnr      = x_major_ff ? y_ff : x_ff;
      maj_next = maj_neg_ff ? maj - 8'd1 : maj + 8'd1;
      mnr_next = min_neg_ff ? mnr - 8'd1 : mnr + 8'd1;
      err_add  = err_ff + $signed({3'b000, dmin_ff});
      // error goes negative after a minor step, so the compare is signed
      min_step = !incl_ff
              && ($signed({err_add[9:0], 1'b0}) >= $signed({3'b000, dmaj_ff}));
      // axis lines end after the end point, sloped ones before it
      line_done = incl_ff ? (maj == end_ff) : (maj_next == end_ff);
   end

   always_comb begin
      mem_addr  = pix_addr;
      mem_we    = 1'b0;
      mem_wdata = cmd_ff.erase ? (rd_data_ff & ~pix_mask) : (rd_data_ff | pix_mask);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr  = clr_cnt_ff;
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         ST_SETUP: begin
            mem_addr = rd_addr;
         end
         ST_PLOT_WR: begin
            mem_we = pix_on;
         end
         default: begin
            mem_addr = pix_addr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_cmd_in    = clr_cmd_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      result_in     = result_ff;
      cmd_in        = cmd_ff;
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      end_in        = end_ff;
      dmaj_in       = dmaj_ff;
      dmin_in       = dmin_ff;
      maj_neg_in    = maj_neg_ff;
      min_neg_in    = min_neg_ff;
      x_major_in    = x_major_ff;
      incl_in       = incl_ff;
      err_in        = err_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == lrpf_pkg::STORE_DEPTH - 1) begin
               clr_cnt_in = '0;
               clr_cmd_in = 1'b0;
               result_in  = '0;
               state_in   = clr_cmd_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = lrpf_pkg::req_data_type'(req_tdata);
               kind_in  = lrpf_pkg::kind_type'(req_tuser);
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            result_in = '0;
            err_in    = '0;
            dmin_in   = '0;
            dmaj_in   = '0;
            unique case (kind_ff)
               lrpf_pkg::KIND_DRAW: begin
                  state_in   = ST_PLOT_RD;
                  maj_neg_in = 1'b0;
                  min_neg_in = 1'b0;
                  incl_in    = 1'b1;
                  if (cmd_ff.x_start == cmd_ff.x_end) begin
                     // vertical line or single point
                     x_major_in = 1'b0;
                     x_in       = cmd_ff.x_start;
                     y_in       = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_start
                                                                  : cmd_ff.y_end;
                     end_in     = (cmd_ff.y_start < cmd_ff.y_end) ? cmd_ff.y_end
                                                                  : cmd_ff.y_start;
                  end else if (cmd_ff.y_start == cmd_ff.y_end) begin
                     x_major_in = 1'b1;
                     y_in       = cmd_ff.y_start;
                     x_in       = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_start
                                                                  : cmd_ff.x_end;
                     end_in     = (cmd_ff.x_start < cmd_ff.x_end) ? cmd_ff.x_end
                                                                  : cmd_ff.x_start;
                  end else begin
                     incl_in    = 1'b0;
                     x_in       = cmd_ff.x_start;
                     y_in       = cmd_ff.y_start;
                     x_major_in = dx_abs > dy_abs;
                     if (dx_abs > dy_abs) begin
                        dmaj_in    = dx_abs;
                        dmin_in    = dy_abs;
                        end_in     = cmd_ff.x_end;
                        maj_neg_in = cmd_ff.x_end < cmd_ff.x_start;
                        min_neg_in = cmd_ff.y_end < cmd_ff.y_start;
                     end else begin
                        dmaj_in    = dy_abs;
                        dmin_in    = dx_abs;
                        end_in     = cmd_ff.y_end;
                        maj_neg_in = cmd_ff.y_end < cmd_ff.y_start;
                        min_neg_in = cmd_ff.x_end < cmd_ff.x_start;
                     end
                  end
               end
               lrpf_pkg::KIND_READ: begin
                  state_in = rd_on ? ST_READ_DATA : ST_RESP;
               end
               lrpf_pkg::KIND_CLEAR: begin
                  clr_cmd_in = 1'b1;
                  clr_cnt_in = '0;
                  state_in   = ST_CLEAR;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_PLOT_RD: begin
            state_in = ST_PLOT_WR;
         end
         ST_PLOT_WR: begin
            if (!incl_ff) begin
               err_in = min_step ? err_add - $signed({3'b000, dmaj_ff}) : err_add;
            end
            if (x_major_ff) begin
               x_in = maj_next;
               y_in = min_step ? mnr_next : mnr;
            end else begin
               y_in = maj_next;
               x_in = min_step ? mnr_next : mnr;
            end
            state_in = line_done ? ST_RESP : ST_PLOT_RD;
         end
         ST_READ_DATA: begin
            result_in = rd_data_ff;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = result_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clr_cmd_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_cmd_ff    <= clr_cmd_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      result_ff    <= result_in;
      cmd_ff       <= cmd_in;
      kind_ff      <= kind_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      end_ff       <= end_in;
      dmaj_ff      <= dmaj_in;
      dmin_ff      <= dmin_in;
      maj_neg_ff   <= maj_neg_in;
      min_neg_ff   <= min_neg_in;
      x_major_ff   <= x_major_in;
      incl_ff      <= incl_in;
      err_ff       <= err_in;
   end

   // one item in flight: accepting closes the input until the command finishes
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a command is in progress");

   // a response only appears out of the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

   // clearing sweep writes zeros every cycle
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> mem_we && (mem_wdata == 8'h00))
      else $error("clearing pass wrote nonzero data");

   // store writes only happen in the clearing or pixel write states
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_PLOT_WR && pix_on))
      else $error("frame store written outside a write state");

endmodule

/* verif/line_raster_to_page_framebuffer_core_test.sv */
`timescale 1ns / 1ps

module line_raster_to_page_framebuffer_core_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int PHASE_ITEMS    = 200;

   class framebuffer_scoreboard;
      logic [7:0] shadow_frame [lrpf_pkg::STORE_DEPTH];
      logic [7:0] expected_bytes [$];
      int errors;
      int draws;
      int reads;
      int clears;
      int others;
      int checked;

      function new();
         wipe_frame();
      endfunction

      function void wipe_frame();
         foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      endfunction

      function void plot(int x, int y, bit erase);
         int idx;
         logic [7:0] mask;
         if (x < 0 || y < 0 || x >= lrpf_pkg::COLUMNS || y >= lrpf_pkg::ROWS) return;
         idx  = (y / 8) * lrpf_pkg::COLUMNS + x;
         mask = lrpf_pkg::PIXEL_BIT << (y % 8);
         if (erase) shadow_frame[idx] = shadow_frame[idx] & ~mask;
         else shadow_frame[idx] = shadow_frame[idx] | mask;
      endfunction

      function void rasterize(int x0, int y0, int x1, int y1, bit erase);
         int lo, hi, dx, dy, sx, sy, x, y, err;
         if (x0 == x1) begin
            lo = (y0 < y1) ? y0 : y1;
            hi = (y0 < y1) ? y1 : y0;
            for (int i = lo; i <= hi; i++) plot(x0, i, erase);
            return;
         end
         if (y0 == y1) begin
            lo = (x0 < x1) ? x0 : x1;
            hi = (x0 < x1) ? x1 : x0;
            for (int i = lo; i <= hi; i++) plot(i, y0, erase);
            return;
         end
         dx  = x1 - x0;
         dy  = y1 - y0;
         sx  = (dx > 0) ? 1 : -1;
         sy  = (dy > 0) ? 1 : -1;
         dx  = (dx < 0) ? -dx : dx;
         dy  = (dy < 0) ? -dy : dy;
         x   = x0;
         y   = y0;
         err = 0;
         // sloped lines stop short of the end point
         if (dx > dy) begin
            while (x != x1) begin
               plot(x, y, erase);
               err += dy;
               if (2 * err >= dx) begin
                  y += sy;
                  err -= dx;
               end
               x += sx;
            end
         end else begin
            while (y != y1) begin
               plot(x, y, erase);
               err += dx;
               if (2 * err >= dy) begin
                  x += sx;
                  err -= dy;
               end
               y += sy;
            end
         end
      endfunction

      function void note_command(lrpf_pkg::kind_type kind, lrpf_pkg::req_data_type fields);
         logic [7:0] data;
         data = 8'h00;
         case (kind)
            lrpf_pkg::KIND_DRAW: begin
               draws++;
               rasterize(int'(fields.x_start), int'(fields.y_start), int'(fields.x_end),
                         int'(fields.y_end), fields.erase);
            end
            lrpf_pkg::KIND_READ: begin
               reads++;
               if (fields.read_page < lrpf_pkg::PAGES
                   && fields.read_column < lrpf_pkg::COLUMNS)
                  data = shadow_frame[int'(fields.read_page) * lrpf_pkg::COLUMNS
                                      + int'(fields.read_column)];
            end
            lrpf_pkg::KIND_CLEAR: begin
               clears++;
               wipe_frame();
            end
            default: others++;
         endcase
         expected_bytes.push_back(data);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_read_data(logic [7:0] got);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("read_data %02h arrived with nothing expected", got));
            return;
         end
         want = expected_bytes.pop_front();
         checked++;
         if (got !== want)
            report_mismatch($sformatf("read_data got %02h want %02h", got, want));
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // x_start, y_start, x_end, y_end, erase, read_page,
                                  // read_column, zero fill
   logic [1:0]  req_tuser = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // read_data

   framebuffer_scoreboard sb = new();

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int last_x = 0;
   int last_y = 0;

   line_raster_to_page_framebuffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // item monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_command(lrpf_pkg::kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_read_data(rsp_tdata);
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic lrpf_pkg::req_data_type random_fields();
      lrpf_pkg::req_data_type d;
      d.pad         = '0;
      d.x_start     = 8'($urandom_range(255));
      d.y_start     = 8'($urandom_range(255));
      d.x_end       = 8'($urandom_range(255));
      d.y_end       = 8'($urandom_range(255));
      d.erase       = 1'($urandom_range(1));
      d.read_page   = 3'($urandom_range(7));
      d.read_column = 7'($urandom_range(127));
      return d;
   endfunction

   function automatic lrpf_pkg::req_data_type line_fields(int xs, int ys, int xe, int ye,
                                                          bit er);
      lrpf_pkg::req_data_type d;
      d         = random_fields();
      d.x_start = 8'(xs);
      d.y_start = 8'(ys);
      d.x_end   = 8'(xe);
      d.y_end   = 8'(ye);
      d.erase   = er;
      return d;
   endfunction

   function automatic lrpf_pkg::req_data_type read_fields(int pg, int col);
      lrpf_pkg::req_data_type d;
      d             = random_fields();
      d.read_page   = 3'(pg);
      d.read_column = 7'(col);
      return d;
   endfunction

   task automatic send_command(input lrpf_pkg::kind_type kind,
                               input lrpf_pkg::req_data_type payload);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = payload;
      req_tuser  = kind;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic draw(int xs, int ys, int xe, int ye, bit er);
      send_command(lrpf_pkg::KIND_DRAW, line_fields(xs, ys, xe, ye, er));
   endtask

   task automatic read_byte(int pg, int col);
      send_command(lrpf_pkg::KIND_READ, read_fields(pg, col));
   endtask

   // stop sending and let every outstanding result come back
   task automatic hold_off();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic random_command();
      int pick, xs, ys, xe, ye;
      pick = $urandom_range(99);
      if (pick < 50) begin
         if ($urandom_range(99) < 15) begin
            xs = $urandom_range(255);
            ys = $urandom_range(255);
            xe = $urandom_range(255);
            ye = $urandom_range(255);
         end else begin
            xs = $urandom_range(135);
            ys = $urandom_range(71);
            xe = $urandom_range(135);
            ye = $urandom_range(71);
         end
         case ($urandom_range(9))
            0: xe = xs;
            1: ye = ys;
            2: begin
               xe = xs;
               ye = ys;
            end
            default: ;
         endcase
         last_x = xs;
         last_y = ys;
         draw(xs, ys, xe, ye, $urandom_range(99) < 30);
      end else if (pick < 92) begin
         // half the reads land on the start of the latest line, wrapped into the frame
         if ($urandom_range(1) == 1) read_byte((last_y / 8) % 8, last_x % 128);
         else read_byte($urandom_range(7), $urandom_range(127));
      end else if (pick < 96) begin
         send_command(lrpf_pkg::KIND_CLEAR, random_fields());
      end else begin
         send_command(lrpf_pkg::KIND_NONE, random_fields());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      read_byte(0, 0);
      draw(0, 0, 127, 0, 1'b0);
      draw(255, 63, 0, 63, 1'b0);
      draw(127, 255, 127, 0, 1'b0);
      draw(5, 9, 5, 9, 1'b0);
      draw(0, 8, 20, 15, 1'b0);
      draw(60, 60, 53, 2, 1'b0);
      draw(0, 40, 2, 41, 1'b0);
      draw(255, 255, 90, 20, 1'b0);
      draw(0, 0, 63, 0, 1'b1);
      send_command(lrpf_pkg::KIND_NONE, line_fields(255, 255, 255, 255, 1'b1));
      read_byte(0, 0);
      read_byte(0, 100);
      read_byte(7, 10);
      read_byte(3, 127);
      read_byte(1, 5);
      read_byte(1, 10);
      read_byte(5, 58);
      read_byte(5, 1);
      read_byte(4, 100);
      send_command(lrpf_pkg::KIND_CLEAR, random_fields());
      read_byte(7, 127);
      read_byte(0, 100);
      hold_off();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 83;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 83;
            end
            default: begin
               sender_idle_pct = 30;
               stall_pct = 30;
            end
         endcase
         repeat (PHASE_ITEMS) random_command();
         hold_off();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

      $display("run covered %0d draws, %0d reads, %0d clears, %0d unused-kind items",
               sb.draws, sb.reads, sb.clears, sb.others);
      $display("%0d results checked under four idle/stall mixes, %0d mismatches",
               sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* line_raster_to_page_framebuffer_core.f */
rtl/core/lrpf_pkg.sv
rtl/core/line_raster_to_page_framebuffer_core.sv
verif/line_raster_to_page_framebuffer_core_test.sv
